[hdl/dcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_pkg
// Types and constants shared by the DC motor tick model.
// ----------------------------------------------------------------------------
package dcm_pkg;

  // Command clamp, 7200.0 in Q16.16
  localparam logic signed [31:0] DUTY_MAX = 32'sd471859200;

  // 2*3.14159 in Q8.24, shifted left 8: divisor of the encoder pulse count
  localparam logic [35:0] TWO_PI_DIV = 36'd26986052608;

  typedef struct packed {
    logic signed [31:0] duty_command;
    logic               clear_count;
  } tick_t;

  typedef struct packed {
    logic signed [29:0] applied_duty;
    logic signed [31:0] speed;
    logic signed [47:0] angle;
    logic signed [31:0] pulse_count;
  } result_t;

  typedef struct packed {
    logic [30:0] accel_limit;
    logic [30:0] decel_limit;
    logic [30:0] duty_slew_limit;
    logic [15:0] speed_per_duty;
    logic [15:0] friction_coeff;
    logic [15:0] pulses_per_rev;
    logic [31:0] tick_seconds;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_SLEW,
    MUL_FRIC,
    MUL_TGT,
    MUL_SSTEP,
    MUL_LOSS,
    MUL_POS,
    MUL_PLO,
    MUL_PHI
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_in;
    logic     cap_duty;
    logic     cap_fric;
    logic     cap_tgt;
    logic     cap_spd;
    logic     cap_loss;
    logic     cap_ang;
    logic     cap_plo;
    logic     div_start;
    logic     cap_cnt;
    logic     ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

[hdl/dcm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_div
// Encoder pulse divider by the fixed 2*pi constant, reciprocal multiply.
// ----------------------------------------------------------------------------
module dcm_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  // dividend < 2^63. Dropping the 8 low bits leaves a divide by DIVISOR.
  // The top 32 bits times floor(2^55 / DIVISOR) give an estimate that is at
  // most two short; the remainder against DIVISOR and 2*DIVISOR fixes it.
  localparam logic [31:0] DIVISOR = 32'd105414268;
  localparam logic [31:0] RECIP   = 32'd341782926;

  typedef enum logic [1:0] {
    D_IDLE,
    D_EST,
    D_BACK,
    D_FIX
  } dstate_t;

  dstate_t     dstate;
  logic [31:0] num_hi, num_lo, est, q;
  logic [63:0] prod;
  logic [31:0] mul_a, mul_b, rem;

  always_comb begin
    unique case (dstate)
      D_EST:   begin mul_a = num_hi;      mul_b = RECIP;   end
      D_BACK:  begin mul_a = prod[63:32]; mul_b = DIVISOR; end
      default: begin mul_a = '0;          mul_b = '0;      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign rem = num_lo - prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (dstate)
        D_IDLE: begin
          if (start) begin
            num_hi <= dividend[62:31];
            num_lo <= dividend[39:8];
            dstate <= D_EST;
          end
        end
        D_EST: begin
          dstate <= D_BACK;
        end
        D_BACK: begin
          est    <= prod[63:32];
          dstate <= D_FIX;
        end
        D_FIX: begin
          if (rem >= {DIVISOR[30:0], 1'b0}) q <= est + 32'd2;
          else if (rem >= DIVISOR) q <= est + 32'd1;
          else q <= est;
          done   <= 1'b1;
          dstate <= D_IDLE;
        end
      endcase
    end
  end

  assign quotient = q;

endmodule

[hdl/dcm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_datapath
// Motor state registers, shared 32x32 multiplier, pulse divider, result reg.
// ----------------------------------------------------------------------------
module dcm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dcm_pkg::dp_cmd_t    cmd,
  input  dcm_pkg::cfg_t       cfg,
  input  dcm_pkg::tick_t      tick,
  output dcm_pkg::dp_status_t status,
  output dcm_pkg::result_t    result
);
  import dcm_pkg::*;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    else if (v < -34'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  logic signed [29:0] cmd_q, duty, tgt;
  logic               clr_q;
  logic signed [31:0] speed;
  logic [47:0]        angle;
  logic [31:0]        count;
  logic signed [32:0] sdiff;
  logic [31:0]        fric;
  logic [47:0]        ds, plo;
  logic [63:0]        p;
  logic [31:0]        mul_a, mul_b;
  logic [31:0]        duty_mag, speed_mag;
  logic signed [31:0] cmd_clamp;
  logic signed [29:0] duty_next, tgt_next;
  logic signed [32:0] sdiff_next;
  logic signed [31:0] speed_slew, speed_fric;
  logic [47:0]        dpos;
  logic [31:0]        pulses;
  logic [63:0]        div_dividend;
  logic [31:0]        quotient;
  logic               div_done;
  result_t            result_q;

  assign duty_mag  = duty[29] ? -32'(duty) : 32'(duty);
  assign speed_mag = speed[31] ? -speed : speed;

  always_comb begin
    if (tick.duty_command > DUTY_MAX) cmd_clamp = DUTY_MAX;
    else if (tick.duty_command < -DUTY_MAX) cmd_clamp = -DUTY_MAX;
    else cmd_clamp = tick.duty_command;
  end

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_NONE:  begin mul_a = '0;                       mul_b = '0;                     end
      MUL_SLEW:  begin mul_a = {1'b0, cfg.duty_slew_limit}; mul_b = cfg.tick_seconds;    end
      MUL_FRIC:  begin mul_a = {16'd0, cfg.friction_coeff}; mul_b = cfg.tick_seconds;    end
      MUL_TGT:   begin mul_a = duty_mag;                 mul_b = {16'd0, cfg.speed_per_duty}; end
      MUL_SSTEP: begin
        mul_a = (sdiff > 33'sd0) ? {1'b0, cfg.accel_limit} : {1'b0, cfg.decel_limit};
        mul_b = cfg.tick_seconds;
      end
      MUL_LOSS:  begin mul_a = speed_mag;                mul_b = fric;                   end
      MUL_POS:   begin mul_a = speed_mag;                mul_b = cfg.tick_seconds;       end
      MUL_PLO:   begin mul_a = ds[31:0];                 mul_b = {16'd0, cfg.pulses_per_rev}; end
      MUL_PHI:   begin mul_a = {16'd0, ds[47:32]};       mul_b = {16'd0, cfg.pulses_per_rev}; end
      default:   begin mul_a = '0;                       mul_b = '0;                     end
    endcase
  end

  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
  end

  // duty slew
  always_comb begin
    logic signed [32:0] dd, dstep, dsum;
    dd    = 33'(cmd_q) - 33'(duty);
    dstep = $signed(33'(p[62:32]));
    if (dd > dstep) dsum = 33'(duty) + dstep;
    else if (dd < -dstep) dsum = 33'(duty) - dstep;
    else dsum = 33'(cmd_q);
    duty_next = dsum[29:0];
  end

  // target speed and its distance from the current speed
  always_comb begin
    logic [29:0] tmag;
    tmag       = p[45:16];
    tgt_next   = duty[29] ? -$signed(tmag) : $signed(tmag);
    sdiff_next = 33'(tgt_next) - 33'(speed);
  end

  // speed slew
  always_comb begin
    logic signed [32:0] sstep;
    sstep = $signed(33'(p[62:32]));
    if (sdiff > sstep) speed_slew = sat32(34'(speed) + 34'(sstep));
    else if (sdiff < -sstep) speed_slew = sat32(34'(speed) - 34'(sstep));
    else speed_slew = 32'(tgt);
  end

  // friction loss, same sign as speed
  always_comb begin
    logic signed [33:0] lmag;
    lmag = $signed(34'(p[63:32]));
    speed_fric = speed[31] ? sat32(34'(speed) + lmag) : sat32(34'(speed) - lmag);
  end

  assign dpos         = speed[31] ? -48'(p[63:32]) : 48'(p[63:32]);
  assign div_dividend = {p[31:0], 32'd0} + {16'd0, plo};
  assign pulses       = speed[31] ? -quotient : quotient;

  dcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      duty  <= '0;
      speed <= '0;
      angle <= '0;
      count <= '0;
    end else begin
      if (cmd.cap_duty) duty <= duty_next;
      if (cmd.cap_spd) speed <= speed_slew;
      else if (cmd.cap_loss) speed <= speed_fric;
      if (cmd.cap_ang) angle <= angle + dpos;
      if (cmd.cap_cnt) count <= (clr_q ? 32'd0 : count) + pulses;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cmd_q <= cmd_clamp[29:0];
      clr_q <= tick.clear_count;
    end
    if (cmd.cap_fric) fric <= p[47:16];
    if (cmd.cap_tgt) begin
      tgt   <= tgt_next;
      sdiff <= sdiff_next;
    end
    if (cmd.cap_ang) ds <= p[63:16];
    if (cmd.cap_plo) plo <= p[47:0];
    if (cmd.ld_out) begin
      result_q.applied_duty <= duty;
      result_q.speed        <= speed;
      result_q.angle        <= $signed(angle);
      result_q.pulse_count  <= $signed(count);
    end
  end

  assign status.div_done = div_done;
  assign result          = result_q;

endmodule

[hdl/dcm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_ctrl
// Sequencer for one motor tick: multiplier schedule, divider, result handoff.
// ----------------------------------------------------------------------------
module dcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick_valid,
  output logic                tick_ready,
  input  logic                result_ready,
  output logic                result_valid,
  output dcm_pkg::dp_cmd_t    cmd,
  input  dcm_pkg::dp_status_t status
);
  import dcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SLEW,
    ST_FRIC,
    ST_TGT,
    ST_DIFF,
    ST_SSTEP,
    ST_SPD,
    ST_LOSS,
    ST_LAPPLY,
    ST_POS,
    ST_ANG,
    ST_PLO,
    ST_PHI,
    ST_DIVLD,
    ST_DIVW,
    ST_CNT,
    ST_DONE
  } state_t;

  state_t state, state_next;

  assign tick_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_valid) begin
          cmd.ld_in  = 1'b1;
          state_next = ST_SLEW;
        end
      end
      ST_SLEW: begin
        cmd.mul_sel = MUL_SLEW;
        state_next  = ST_FRIC;
      end
      ST_FRIC: begin
        cmd.mul_sel  = MUL_FRIC;
        cmd.cap_duty = 1'b1;
        state_next   = ST_TGT;
      end
      ST_TGT: begin
        cmd.mul_sel  = MUL_TGT;
        cmd.cap_fric = 1'b1;
        state_next   = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.cap_tgt = 1'b1;
        state_next  = ST_SSTEP;
      end
      ST_SSTEP: begin
        cmd.mul_sel = MUL_SSTEP;
        state_next  = ST_SPD;
      end
      ST_SPD: begin
        cmd.cap_spd = 1'b1;
        state_next  = ST_LOSS;
      end
      ST_LOSS: begin
        cmd.mul_sel = MUL_LOSS;
        state_next  = ST_LAPPLY;
      end
      ST_LAPPLY: begin
        cmd.cap_loss = 1'b1;
        state_next   = ST_POS;
      end
      ST_POS: begin
        cmd.mul_sel = MUL_POS;
        state_next  = ST_ANG;
      end
      ST_ANG: begin
        cmd.cap_ang = 1'b1;
        state_next  = ST_PLO;
      end
      ST_PLO: begin
        cmd.mul_sel = MUL_PLO;
        state_next  = ST_PHI;
      end
      ST_PHI: begin
        cmd.mul_sel = MUL_PHI;
        cmd.cap_plo = 1'b1;
        state_next  = ST_DIVLD;
      end
      ST_DIVLD: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVW;
      end
      ST_DIVW: begin
        if (status.div_done) state_next = ST_CNT;
      end
      ST_CNT: begin
        cmd.cap_cnt = 1'b1;
        state_next  = ST_DONE;
      end
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.ld_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.ld_out) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

endmodule

[hdl/dc_motor_model_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dc_motor_model_step
// DC motor tick model: duty slew, speed slew, friction, position, encoder.
// ----------------------------------------------------------------------------
// Usage:
//   tick (valid/ready) carries one time tick: commanded duty (Q16.16) and
//   the clear-count flag. result (valid/ready) returns applied duty, speed,
//   angle and encoder count after that tick, one transaction per tick.
//   The APB port holds seven registers at byte addresses 0x00..0x18; write
//   them only while no tick is in flight. pready is tied high.
// Timing:
//   One tick at a time. A tick runs from acceptance to result valid
//   through the shared 32x32 multiplier schedule, then the reciprocal
//   divider that converts distance to encoder pulses, then the count
//   update and the result load. tick_ready returns with the result, so a
//   new tick is taken while the previous result still waits in the
//   output register.
// Reset:
//   rst clears duty, speed, angle and count and restores register defaults.
// Stall:
//   If result_ready is low, the next finished tick holds in the sequencer
//   until the output register frees; no tick is accepted meanwhile.
// ----------------------------------------------------------------------------
module dc_motor_model_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              tick_valid,
  output logic              tick_ready,
  input  dcm_pkg::tick_t    tick,
  output logic              result_valid,
  input  logic              result_ready,
  output dcm_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import dcm_pkg::*;

  localparam logic [2:0] REG_ACCEL = 3'd0;
  localparam logic [2:0] REG_DECEL = 3'd1;
  localparam logic [2:0] REG_SLEW  = 3'd2;
  localparam logic [2:0] REG_SPD   = 3'd3;
  localparam logic [2:0] REG_FRIC  = 3'd4;
  localparam logic [2:0] REG_PPR   = 3'd5;
  localparam logic [2:0] REG_TICK  = 3'd6;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_limit     <= '0;
      cfg.decel_limit     <= '0;
      cfg.duty_slew_limit <= '0;
      cfg.speed_per_duty  <= 16'd655;
      cfg.friction_coeff  <= 16'd6554;
      cfg.pulses_per_rev  <= 16'd1000;
      cfg.tick_seconds    <= 32'd4294967;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ACCEL: cfg.accel_limit     <= pwdata[30:0];
        REG_DECEL: cfg.decel_limit     <= pwdata[30:0];
        REG_SLEW:  cfg.duty_slew_limit <= pwdata[30:0];
        REG_SPD:   cfg.speed_per_duty  <= pwdata[15:0];
        REG_FRIC:  cfg.friction_coeff  <= pwdata[15:0];
        REG_PPR:   cfg.pulses_per_rev  <= pwdata[15:0];
        REG_TICK:  cfg.tick_seconds    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_ACCEL: prdata = {1'b0, cfg.accel_limit};
      REG_DECEL: prdata = {1'b0, cfg.decel_limit};
      REG_SLEW:  prdata = {1'b0, cfg.duty_slew_limit};
      REG_SPD:   prdata = {16'd0, cfg.speed_per_duty};
      REG_FRIC:  prdata = {16'd0, cfg.friction_coeff};
      REG_PPR:   prdata = {16'd0, cfg.pulses_per_rev};
      REG_TICK:  prdata = cfg.tick_seconds;
      default:   prdata = '0;
    endcase
  end

  dcm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_ready   (tick_ready),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .cmd          (cmd),
    .status       (status)
  );

  dcm_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .tick   (tick),
    .status (status),
    .result (result)
  );

endmodule

[hdl/dcm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcm_checker
// Port-level checks on the tick/result sequencing of the motor model.
// ----------------------------------------------------------------------------
module dcm_checker (
  input logic             clk,
  input logic             rst,
  input logic             tick_valid,
  input logic             tick_ready,
  input logic             result_valid,
  input logic             result_ready,
  input dcm_pkg::result_t result
);
  import dcm_pkg::*;

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // one tick in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted while another is in flight");

  // a new result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!tick_ready))
    else $error("result appeared without a tick in flight");

  // idle and empty after reset
  a_reset_idle: assert property (@(posedge clk)
    $fell(rst) |-> tick_ready && !result_valid)
    else $error("not idle after reset");

endmodule

bind dc_motor_model_step dcm_checker u_dcm_checker (.*);
